### hdl/ooobt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ooobt_pkg;

	localparam int MAX_BLOCKS = 8;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int SEQ_W      = 32;
	localparam int LEN_W      = 16;
	localparam int STAT_W     = 3;
	localparam int BCNT_W     = 4;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STAT_W-1:0] ST_EXTENDED  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_OVERLAP   = 3'd3;
	localparam logic [STAT_W-1:0] ST_POPPED    = 3'd4;
	localparam logic [STAT_W-1:0] ST_POP_EMPTY = 3'd5;

	typedef logic [2:0] op_t;

	localparam op_t OP_HOLD        = 3'd0;
	localparam op_t OP_LOAD_NEW    = 3'd1;
	localparam op_t OP_SET_HEAD    = 3'd2;
	localparam op_t OP_SET_TAIL    = 3'd3;
	localparam op_t OP_TAIL_NEXT   = 3'd4;
	localparam op_t OP_FROM_PREV   = 3'd5;
	localparam op_t OP_FROM_NEXT   = 3'd6;

	typedef struct packed {
		logic head_after_seq;
		logic head_after_end;
		logic head_is_end;
		logic tail_after_seq;
		logic tail_is_seq;
		logic seq_after_tail;
	} flags_t;

	// Wraparound order: a is after b when a - b is positive as a signed value.
	function automatic logic seq_after(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[SEQ_W-1];
	endfunction

endpackage
`default_nettype wire

### hdl/ooobt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ooobt_cell (
	input  logic                          clk,
	input  ooobt_pkg::op_t                op,
	input  logic                          eval_en,
	input  logic [ooobt_pkg::SEQ_W-1:0]   seg_seq,
	input  logic [ooobt_pkg::SEQ_W-1:0]   seg_end,
	input  logic [ooobt_pkg::SEQ_W-1:0]   prev_head,
	input  logic [ooobt_pkg::SEQ_W-1:0]   prev_tail,
	input  logic [ooobt_pkg::SEQ_W-1:0]   next_head,
	input  logic [ooobt_pkg::SEQ_W-1:0]   next_tail,
	output logic [ooobt_pkg::SEQ_W-1:0]   head,
	output logic [ooobt_pkg::SEQ_W-1:0]   tail,
	output ooobt_pkg::flags_t             flags
);
	import ooobt_pkg::*;

	logic [SEQ_W-1:0] head_q;
	logic [SEQ_W-1:0] tail_q;
	flags_t           flags_q;

	always_ff @(posedge clk) begin
		if (eval_en) begin
			flags_q.head_after_seq <= seq_after(head_q, seg_seq);
			flags_q.head_after_end <= seq_after(head_q, seg_end);
			flags_q.head_is_end    <= (head_q == seg_end);
			flags_q.tail_after_seq <= seq_after(tail_q, seg_seq);
			flags_q.tail_is_seq    <= (tail_q == seg_seq);
			flags_q.seq_after_tail <= seq_after(seg_seq, tail_q);
		end
		case (op)
			OP_LOAD_NEW: begin
				head_q <= seg_seq;
				tail_q <= seg_end;
			end
			OP_SET_HEAD:  head_q <= seg_seq;
			OP_SET_TAIL:  tail_q <= seg_end;
			OP_TAIL_NEXT: tail_q <= next_tail;
			OP_FROM_PREV: begin
				head_q <= prev_head;
				tail_q <= prev_tail;
			end
			OP_FROM_NEXT: begin
				head_q <= next_head;
				tail_q <= next_tail;
			end
			default: begin
				head_q <= head_q;
				tail_q <= tail_q;
			end
		endcase
	end

	assign head  = head_q;
	assign tail  = tail_q;
	assign flags = flags_q;

endmodule
`default_nettype wire

### hdl/ooobt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ooobt_ctrl (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic                                      in_command,
	input  logic [ooobt_pkg::SEQ_W-1:0]               in_seq,
	input  logic [ooobt_pkg::LEN_W-1:0]               in_length,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [ooobt_pkg::STAT_W-1:0]              out_status,
	output logic [ooobt_pkg::BCNT_W-1:0]              out_count,
	output logic [ooobt_pkg::SEQ_W-1:0]               out_head,
	output logic [ooobt_pkg::SEQ_W-1:0]               out_tail,
	input  ooobt_pkg::flags_t [ooobt_pkg::MAX_BLOCKS-1:0] flags,
	input  logic [ooobt_pkg::SEQ_W-1:0]               first_head,
	input  logic [ooobt_pkg::SEQ_W-1:0]               first_tail,
	output logic                                      eval_en,
	output logic [ooobt_pkg::SEQ_W-1:0]               seg_seq,
	output logic [ooobt_pkg::SEQ_W-1:0]               seg_end,
	output ooobt_pkg::op_t [ooobt_pkg::MAX_BLOCKS-1:0] ops
);
	import ooobt_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EVAL  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;
	localparam logic [1:0] S_RESP  = 2'd3;

	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic              cmd_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [SEQ_W-1:0]  end_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [STAT_W-1:0] status_q;
	logic [STAT_W-1:0] status_d;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [BCNT_W-1:0] out_count_q;
	logic [SEQ_W-1:0]  out_head_q;
	logic [SEQ_W-1:0]  out_tail_q;

	logic              out_free;
	logic              accept;
	logic              load_out;
	logic              full;
	logic              found;
	logic [IDX_W-1:0]  idx;
	logic [IDX_W-1:0]  idx_nx;
	logic              idx_last;
	logic              idx_top;
	flags_t            fl;
	flags_t            fln;
	logic              do_ins;
	logic [IDX_W-1:0]  ins_pos;
	logic              do_head;
	logic              do_tail;
	logic              do_merge;
	logic              do_pop;
	logic [MAX_BLOCKS-1:0] decide;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_RESP) && out_free);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == S_RESP) && out_free;
	assign eval_en  = (state_q == S_EVAL);
	assign full     = (count_q == CNT_W'(MAX_BLOCKS));

	// A cell decides the walk when the segment lies before it, touches or overlaps it,
	// or lies beyond it and it is the last one held.
	always_comb begin
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			decide[i] = (CNT_W'(i) < count_q) &&
				(flags[i].head_after_seq || flags[i].tail_after_seq ||
				 flags[i].tail_is_seq ||
				 (flags[i].seq_after_tail && (CNT_W'(i + 1) == count_q)));
		end
		found = 1'b0;
		idx   = '0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			if (!found && decide[i]) begin
				found = 1'b1;
				idx   = IDX_W'(i);
			end
		end
	end

	assign idx_top  = (idx == IDX_W'(MAX_BLOCKS - 1));
	assign idx_nx   = idx_top ? '0 : idx + IDX_W'(1);
	assign idx_last = ((CNT_W'(idx) + CNT_W'(1)) == count_q);
	assign fl       = flags[idx];
	assign fln      = flags[idx_nx];

	always_comb begin
		do_ins   = 1'b0;
		ins_pos  = idx;
		do_head  = 1'b0;
		do_tail  = 1'b0;
		do_merge = 1'b0;
		do_pop   = 1'b0;
		status_d = ST_OVERLAP;
		count_d  = count_q;
		if (cmd_q == CMD_POP) begin
			if (count_q == '0) begin
				status_d = ST_POP_EMPTY;
			end else begin
				do_pop   = 1'b1;
				status_d = ST_POPPED;
				count_d  = count_q - CNT_W'(1);
			end
		end else if (!found) begin
			if (count_q == '0) begin
				do_ins   = 1'b1;
				ins_pos  = '0;
				status_d = ST_ADDED;
				count_d  = CNT_W'(1);
			end
		end else if (fl.head_after_seq) begin
			if (fl.head_after_end) begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					do_ins   = 1'b1;
					status_d = ST_ADDED;
					count_d  = count_q + CNT_W'(1);
				end
			end else if (fl.head_is_end) begin
				do_head  = 1'b1;
				status_d = ST_EXTENDED;
			end
		end else if (fl.tail_after_seq) begin
			status_d = ST_OVERLAP;
		end else if (fl.tail_is_seq) begin
			if (idx_last || idx_top || fln.head_after_end) begin
				do_tail  = 1'b1;
				status_d = ST_EXTENDED;
			end else if (fln.head_is_end) begin
				// The segment closes the gap: the two intervals merge into one.
				do_merge = 1'b1;
				status_d = ST_EXTENDED;
				count_d  = count_q - CNT_W'(1);
			end
		end else begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				do_ins   = 1'b1;
				ins_pos  = idx_nx;
				status_d = ST_ADDED;
				count_d  = count_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_BLOCKS; j++) begin
			ops[j] = OP_HOLD;
			if (state_q == S_APPLY) begin
				if (do_pop) begin
					ops[j] = OP_FROM_NEXT;
				end else if (do_ins) begin
					if (IDX_W'(j) > ins_pos)
						ops[j] = OP_FROM_PREV;
					else if (IDX_W'(j) == ins_pos)
						ops[j] = OP_LOAD_NEW;
				end else if (do_head) begin
					if (IDX_W'(j) == idx)
						ops[j] = OP_SET_HEAD;
				end else if (do_tail) begin
					if (IDX_W'(j) == idx)
						ops[j] = OP_SET_TAIL;
				end else if (do_merge) begin
					if (IDX_W'(j) > idx)
						ops[j] = OP_FROM_NEXT;
					else if (IDX_W'(j) == idx)
						ops[j] = OP_TAIL_NEXT;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_EVAL;
			S_EVAL:  state_d = S_APPLY;
			S_APPLY: state_d = S_RESP;
			S_RESP: begin
				if (accept)
					state_d = S_EVAL;
				else if (load_out)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_APPLY)
				count_q <= count_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_command;
			seq_q <= in_seq;
			end_q <= in_seq + SEQ_W'(in_length);
		end
		if (state_q == S_APPLY)
			status_q <= status_d;
		if (load_out) begin
			out_status_q <= status_q;
			out_count_q  <= BCNT_W'(count_q);
			out_head_q   <= (count_q == '0) ? '0 : first_head;
			out_tail_q   <= (count_q == '0) ? '0 : first_tail;
		end
	end

	assign seg_seq    = seq_q;
	assign seg_end    = end_q;
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_count  = out_count_q;
	assign out_head   = out_head_q;
	assign out_tail   = out_tail_q;

endmodule
`default_nettype wire

### hdl/out_of_order_block_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Tracks up to eight received but unsequenced intervals [head, tail) of 32-bit
// sequence numbers, kept in order in a row of cells that shift up or down together.
// The slave channel takes one command word: tuser selects insert or pop, tdata
// carries the segment start and length. The master channel returns one word per
// command with the status in tuser and, in tdata, the interval count and the first
// interval after the operation (zeros when the list is empty).
// A word is accepted on the slave side, its compares are registered in the cells,
// then the list is updated, and then the result word is loaded into the output
// register once that register is free. A new command can be taken in the same
// cycle as that load, so a command is not started before the last one is through;
// the pace of back-to-back commands is set by the compare, decide-and-shift and
// result stages of the cell row.
// The output register holds its word while the receiver stalls. One further command
// is still accepted; it runs through the compare and the update and then waits in
// the result stage, with the slave side held off, until the waiting word has gone.
// Reset empties the list and drops any word in flight; no clearing pass is needed.
module out_of_order_block_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // seq [31:0], length [47:32]
	input  logic        s_axis_tuser,  // command [0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // block_count [3:0], first_head [35:4], first_tail [67:36]
	output logic [2:0]  m_axis_tuser   // status [2:0]
);
	import ooobt_pkg::*;

	logic [SEQ_W-1:0]          heads [MAX_BLOCKS];
	logic [SEQ_W-1:0]          tails [MAX_BLOCKS];
	flags_t [MAX_BLOCKS-1:0]   flags;
	op_t [MAX_BLOCKS-1:0]      ops;
	logic                      eval_en;
	logic [SEQ_W-1:0]          seg_seq;
	logic [SEQ_W-1:0]          seg_end;
	logic [BCNT_W-1:0]         out_count;
	logic [SEQ_W-1:0]          out_head;
	logic [SEQ_W-1:0]          out_tail;

	ooobt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_command (s_axis_tuser),
		.in_seq     (s_axis_tdata[31:0]),
		.in_length  (s_axis_tdata[47:32]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_count  (out_count),
		.out_head   (out_head),
		.out_tail   (out_tail),
		.flags      (flags),
		.first_head (heads[0]),
		.first_tail (tails[0]),
		.eval_en    (eval_en),
		.seg_seq    (seg_seq),
		.seg_end    (seg_end),
		.ops        (ops)
	);

	// Each cell sees its neighbours; the ends of the row see zeros.
	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		ooobt_cell u_cell (
			.clk       (clk),
			.op        (ops[g]),
			.eval_en   (eval_en),
			.seg_seq   (seg_seq),
			.seg_end   (seg_end),
			.prev_head ((g == 0) ? '0 : heads[(g == 0) ? 0 : g - 1]),
			.prev_tail ((g == 0) ? '0 : tails[(g == 0) ? 0 : g - 1]),
			.next_head ((g == MAX_BLOCKS - 1) ? '0 : heads[(g == MAX_BLOCKS - 1) ? g : g + 1]),
			.next_tail ((g == MAX_BLOCKS - 1) ? '0 : tails[(g == MAX_BLOCKS - 1) ? g : g + 1]),
			.head      (heads[g]),
			.tail      (tails[g]),
			.flags     (flags[g])
		);
	end

	assign m_axis_tdata = {4'b0000, out_tail, out_head, out_count};

endmodule
`default_nettype wire
